/* rtl/gbfo_pkg.sv */
package gbfo_pkg;

   localparam int MaxVertices = 64;
   localparam int MaxEdges = 256;
   localparam int VertexWidth = 6;
   localparam int EdgeIndexWidth = 8;
   localparam int EdgeCountWidth = 9;
   localparam int QueueCountWidth = 7;
   localparam int CountWidth = 7;

   typedef enum logic [1:0] {
      ACTION_CLEAR = 2'd0,
      ACTION_ADD = 2'd1,
      ACTION_RUN = 2'd2,
      ACTION_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BAD_START = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] first_end;
      logic [5:0] second_end;
      logic [5:0] start_vertex;
   } req_type;

   typedef struct packed {
      logic [5:0] visited_vertex;
      logic last;
      logic [1:0] status;
   } rsp_type;

endpackage

/* rtl/graph_breadth_first_order.sv */
// Breadth-first visit order of an undirected graph held in a 256-entry edge memory.
// Clear and add-edge transfers can follow back to back. A run transfer first clears the seen
// map and queues the start vertex, then pops one queued vertex at a time and scans the stored
// edges for it, one edge per cycle. One result is offered per dequeued vertex; the scan of
// the next vertex waits until that result transfer completes. The single edge memory read
// port sets the rate.
module graph_breadth_first_order import gbfo_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CountWidth-1:0] csr_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_SWEEP = 8'b00000010,
      ST_POP   = 8'b00000100,
      ST_QREAD = 8'b00001000,
      ST_SCAN  = 8'b00010000,
      ST_LAST  = 8'b00100000,
      ST_SEND  = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [2*VertexWidth-1:0] edge_mem [MaxEdges];
   logic [VertexWidth-1:0] queue_mem [MaxVertices];
   logic seen_mem [MaxVertices];

   logic [2*VertexWidth-1:0] edge_rd_ff;
   logic [VertexWidth-1:0] queue_rd_ff;
   logic seen_rd_ff;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [EdgeCountWidth-1:0] edge_total_ff, edge_total_in;
   logic dropped_ff, dropped_in;
   logic [QueueCountWidth-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [EdgeCountWidth-1:0] scan_ff, scan_in;
   logic [VertexWidth-1:0] cur_ff, cur_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic [VertexWidth-1:0] ex, ey, cand;
   logic hit, cand_ok;
   logic [VertexWidth-1:0] probe_ff;
   logic probe_valid_ff;
   logic [VertexWidth-1:0] probe_in;
   logic probe_valid_in;
   logic [VertexWidth-1:0] recent_ff, recent_in;
   logic recent_valid_ff, recent_valid_in;

   function automatic logic in_range(input logic [VertexWidth-1:0] v,
                                     input logic [CountWidth-1:0] n);
      in_range = {1'b0, v} < n;
   endfunction

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign ex = edge_rd_ff[VertexWidth-1:0];
   assign ey = edge_rd_ff[2*VertexWidth-1:VertexWidth];
   assign cand = (ex == cur_ff) ? ey : ex;
   assign hit = in_range(ex, count_ff) && in_range(ey, count_ff) &&
                ((ex == cur_ff) || (ey == cur_ff));

   // Scanned edge from last cycle probes seen map now; a self loop is caught by the seen map, and a
   // second hit on the same vertex right after it was queued is resolved through the recent-write forward.
   assign cand_ok = probe_valid_ff && !seen_rd_ff &&
                    !(recent_valid_ff && recent_ff == probe_ff) &&
                    (tail_ff < QueueCountWidth'(MaxVertices));

   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACTION_ADD && edge_total_ff < EdgeCountWidth'(MaxEdges)
          && in_range(req_data.first_end, count_ff) && in_range(req_data.second_end, count_ff))
      begin
         edge_mem[edge_total_ff[EdgeIndexWidth-1:0]] <= {req_data.second_end, req_data.first_end};
      end
      edge_rd_ff <= edge_mem[scan_ff[EdgeIndexWidth-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SWEEP) begin
         seen_mem[scan_ff[VertexWidth-1:0]] <= 1'b0;
      end else if (state_ff == ST_DONE) begin
         seen_mem[cur_ff] <= 1'b1;
      end else if (cand_ok) begin
         seen_mem[probe_ff] <= 1'b1;
      end
      seen_rd_ff <= seen_mem[probe_in];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         queue_mem[tail_ff[VertexWidth-1:0]] <= cur_ff;
      end else if (cand_ok) begin
         queue_mem[tail_ff[VertexWidth-1:0]] <= probe_ff;
      end
      queue_rd_ff <= queue_mem[head_ff[VertexWidth-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      edge_total_in = edge_total_ff;
      dropped_in = dropped_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      scan_in = scan_ff;
      cur_in = cur_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      probe_in = cand;
      probe_valid_in = 1'b0;
      recent_in = recent_ff;
      recent_valid_in = recent_valid_ff;
      if (cand_ok) begin
         tail_in = tail_ff + 1'b1;
         recent_in = probe_ff;
         recent_valid_in = 1'b1;
      end
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.action)
                  ACTION_CLEAR: begin
                     edge_total_in = '0;
                     dropped_in = 1'b0;
                  end
                  ACTION_ADD: begin
                     if (edge_total_ff >= EdgeCountWidth'(MaxEdges) ||
                         !in_range(req_data.first_end, count_ff) ||
                         !in_range(req_data.second_end, count_ff)) begin
                        dropped_in = 1'b1;
                     end else begin
                        edge_total_in = edge_total_ff + 1'b1;
                     end
                  end
                  ACTION_RUN: begin
                     if (!in_range(req_data.start_vertex, count_ff)) begin
                        rsp_in = '{visited_vertex: '0, last: 1'b1,
                                   status: STATUS_BAD_START};
                        rsp_valid_in = 1'b1;
                        state_in = ST_SEND;
                     end else begin
                        cur_in = req_data.start_vertex;
                        status_in = dropped_ff ? STATUS_DROPPED : STATUS_OK;
                        scan_in = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == EdgeCountWidth'(MaxVertices - 1)) begin
               head_in = '0;
               tail_in = '0;
               recent_valid_in = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            tail_in = QueueCountWidth'(1);
            state_in = ST_POP;
         end
         ST_POP: begin
            recent_valid_in = 1'b0;
            if (rsp_valid_ff) begin
               state_in = ST_POP;
            end else if (head_ff == tail_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_QREAD;
            end
         end
         ST_QREAD: begin
            cur_in = queue_rd_ff;
            head_in = head_ff + 1'b1;
            scan_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            probe_valid_in = (scan_ff != '0) && hit;
            if (scan_ff >= edge_total_ff) begin
               state_in = ST_LAST;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_LAST: begin
            rsp_in = '{visited_vertex: cur_ff, last: (head_ff == tail_in),
                       status: status_ff};
            rsp_valid_in = 1'b1;
            state_in = ST_POP;
         end
         ST_SEND: begin
            if (!rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CountWidth'(MaxVertices);
         edge_total_ff <= '0;
         dropped_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         probe_valid_ff <= 1'b0;
         recent_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         edge_total_ff <= edge_total_in;
         dropped_ff <= dropped_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         scan_ff <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         probe_valid_ff <= probe_valid_in;
         recent_valid_ff <= recent_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      status_ff <= status_in;
      rsp_ff <= rsp_in;
      probe_ff <= probe_in;
      recent_ff <= recent_in;
   end

   // The queue never passes its capacity and the head never passes the tail.
   assert property (@(posedge clock) disable iff (reset)
      tail_ff <= QueueCountWidth'(MaxVertices) && head_ff <= tail_ff)
      else $error("queue pointers out of order");

   // The edge count never exceeds the memory depth.
   assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EdgeCountWidth'(MaxEdges))
      else $error("edge count overflow");

   // A new result is only produced once the previous one has been taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |-> !rsp_valid_ff)
      else $error("result overwritten");

   // Inputs are only taken while idle.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE))
      else $error("transfer taken while busy");

endmodule

/* tb/sv/tb_graph_breadth_first_order.sv */
`timescale 1ns / 100ps

module tb_graph_breadth_first_order;
   import gbfo_pkg::*;

   localparam int StallLimit = 20000;

   typedef struct {
      bit is_cfg;
      int count;
      req_type item;
      bit fixed;
      rsp_type answer;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CountWidth-1:0] csr_data = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int quiet_cycles = 0;
   rsp_type order_q[$];

   logic [VertexWidth-1:0] edge_a [MaxEdges];
   logic [VertexWidth-1:0] edge_b [MaxEdges];
   int edge_total = 0;
   bit dropped = 0;
   int vertex_limit = MaxVertices;

   graph_breadth_first_order u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit in_range(int v);
      return v < vertex_limit && v < MaxVertices;
   endfunction

   // Updates the graph state for one accepted transfer and queues the visit order it causes.
   function automatic void predict_order(req_type r);
      bit seen [MaxVertices];
      int fifo [MaxVertices];
      int head;
      int tail;
      int u;
      logic [1:0] st;
      rsp_type o;
      case (action_type'(r.action))
         ACTION_CLEAR: begin
            edge_total = 0;
            dropped = 0;
         end
         ACTION_ADD: begin
            if (edge_total >= MaxEdges || !in_range(r.first_end) || !in_range(r.second_end)) begin
               dropped = 1;
            end else begin
               edge_a[edge_total] = r.first_end;
               edge_b[edge_total] = r.second_end;
               edge_total++;
            end
         end
         ACTION_RUN: begin
            if (!in_range(r.start_vertex)) begin
               o.visited_vertex = '0;
               o.last = 1'b1;
               o.status = STATUS_BAD_START;
               order_q.insert(order_q.size(), o);
            end else begin
               st = dropped ? STATUS_DROPPED : STATUS_OK;
               foreach (seen[i]) seen[i] = 0;
               head = 0;
               tail = 1;
               fifo[0] = r.start_vertex;
               seen[r.start_vertex] = 1;
               while (head < tail) begin
                  u = fifo[head++];
                  for (int i = 0; i < edge_total; i++) begin
                     if (in_range(edge_a[i]) && in_range(edge_b[i])) begin
                        if (edge_a[i] == u && !seen[edge_b[i]]) begin
                           seen[edge_b[i]] = 1;
                           fifo[tail++] = edge_b[i];
                        end
                        if (edge_b[i] == u && !seen[edge_a[i]]) begin
                           seen[edge_a[i]] = 1;
                           fifo[tail++] = edge_a[i];
                        end
                     end
                  end
                  o.visited_vertex = u[VertexWidth-1:0];
                  o.last = (head == tail);
                  o.status = st;
                  order_q.insert(order_q.size(), o);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(req_type r, bit fixed, rsp_type answer);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (fixed) begin
         predict_order(r);
         void'(order_q.pop_back());
         order_q.insert(order_q.size(), answer);
      end else begin
         predict_order(r);
      end
   endtask

   task automatic set_vertex_count(int v);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (order_q.size() == 0);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v[CountWidth-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vertex_limit = v;
   endtask

   function automatic req_type make_item(action_type a, int f, int s, int v);
      req_type r;
      r.action = a;
      r.first_end = f[5:0];
      r.second_end = s[5:0];
      r.start_vertex = v[5:0];
      return r;
   endfunction

   function automatic int pick_vertex();
      if ($urandom_range(9) == 0) return $urandom_range(63);
      return $urandom_range(vertex_limit - 1);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (order_q.size() == 0) begin
            $error("result transfer with nothing expected: %p", rsp_data);
            failures++;
         end else begin
            e = order_q.pop_front();
            if (rsp_data.visited_vertex !== e.visited_vertex) begin
               $error("visited_vertex expected %0d actual %0d", e.visited_vertex,
                      rsp_data.visited_vertex);
               failures++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_data.last);
               failures++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      step_type plan [$];
      step_type s;
      rsp_type none;
      int n;
      none = '0;
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 0), 1,
                                 '{6'd0, 1'b1, STATUS_OK}});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 63), 1,
                                 '{6'd63, 1'b1, STATUS_OK}});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 0, 63, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 63, 5, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 5, 5, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 0, 1, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 1, 12, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 12, 63, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_NONE, 63, 63, 63), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 63, 63, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 5), 0, none});
      plan.insert(plan.size(), '{1, 10, make_item(ACTION_NONE, 0, 0, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 10), 1,
                                 '{6'd0, 1'b1, STATUS_BAD_START}});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 0, 20, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 1), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_CLEAR, 0, 0, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 3), 1,
                                 '{6'd3, 1'b1, STATUS_OK}});
      plan.insert(plan.size(), '{1, 1, make_item(ACTION_NONE, 0, 0, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_ADD, 0, 0, 0), 0, none});
      plan.insert(plan.size(), '{0, 0, make_item(ACTION_RUN, 0, 0, 0), 1,
                                 '{6'd0, 1'b1, STATUS_OK}});
      plan.insert(plan.size(), '{1, 64, make_item(ACTION_NONE, 0, 0, 0), 0, none});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         s = plan[i];
         if (s.is_cfg) set_vertex_count(s.count);
         else send_item(s.item, s.fixed, s.answer);
      end

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 27) : 0;
         stall_pct = (ph == 2) ? 71 : ((ph == 3) ? 27 : 0);
         for (int seq = 0; seq < 2; seq++) begin
            set_vertex_count((seq == 0) ? ((ph % 2) ? 1 : 64) : $urandom_range(1, 64));
            send_item(make_item(ACTION_CLEAR, $urandom_range(63), $urandom_range(63),
                                $urandom_range(63)), 0, none);
            n = $urandom_range(0, 14);
            repeat (n) begin
               send_item(make_item(ACTION_ADD, pick_vertex(), pick_vertex(),
                                   $urandom_range(63)), 0, none);
            end
            if ($urandom_range(3) == 0) begin
               send_item(make_item(ACTION_NONE, $urandom_range(63), $urandom_range(63),
                                   $urandom_range(63)), 0, none);
            end
            repeat (2) begin
               send_item(make_item(ACTION_RUN, $urandom_range(63), $urandom_range(63),
                                   pick_vertex()), 0, none);
            end
         end
      end

      req_valid <= 1'b0;
      wait (order_q.size() == 0);
      repeat (300) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
